@@ design/bct_pkg.sv @@
`timescale 1ns / 1ps

package bct_pkg;

   localparam int COORD_W    = 32;
   localparam int NUM_COORDS = 4;
   localparam int IDX_W      = 6;
   localparam int STEPS_W    = 6;
   localparam int CNT_W      = 3;

   localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd16;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } seq_state_type;

   // point store control from the sequencer
   typedef struct packed {
      logic             wr;
      logic             cp;
      logic [CNT_W-1:0] slot;
      logic [CNT_W-1:0] src;
   } store_ctl_type;

   // per-sample tag that travels alongside the lanes
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             run_end;
   } sample_meta_type;

endpackage

@@ design/bezier_chain_tessellator_top.sv @@
`timescale 1ns / 1ps

// Control points of a chain enter one word at a time on start/busy and are
// grouped into Bezier segments of up to MAX_ORDER points, each later segment
// reusing the last point of the one before. A word that completes no segment
// leaves busy low. A word that completes a segment (a full one, or the chain's
// final point with two or more points held) raises busy while a bit-serial
// divider forms the t step from steps, then while one sample a cycle enters
// the four coordinate lanes, steps+1 samples in all; a steps value of 0
// counts as 1. Each sample passes the lane stages and the output register to
// the rsp_ ports, marked by rsp_strobe for one cycle, and rsp_run_end flags
// the last sample of the segment. The receiver cannot stall: every strobed
// word must be taken when it appears. csr_wdata sets steps (reset 16); the
// user must see that it is only written while the block is idle, unenforced.

module bezier_chain_tessellator_top #(
   parameter int MAX_ORDER = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [bct_pkg::COORD_W-1:0]  req_px,
   input  logic signed [bct_pkg::COORD_W-1:0]  req_py,
   input  logic signed [bct_pkg::COORD_W-1:0]  req_pz,
   input  logic signed [bct_pkg::COORD_W-1:0]  req_pw,
   input  logic                                req_final_point,
   input  logic                                csr_we,
   input  logic [bct_pkg::STEPS_W-1:0]         csr_wdata,
   output logic                                rsp_strobe,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cx,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cy,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cz,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cw,
   output logic [bct_pkg::IDX_W-1:0]           rsp_sample_index,
   output logic                                rsp_run_end
);

   localparam int CW   = bct_pkg::COORD_W;
   localparam int NC   = bct_pkg::NUM_COORDS;
   localparam int SLTW = $clog2(MAX_ORDER);

   bct_pkg::store_ctl_type   store;
   bct_pkg::sample_meta_type meta;
   logic [bct_pkg::CNT_W-1:0] npts;
   logic [FRAC_BITS:0]        t_val;

   logic signed [CW-1:0] pts_ff   [MAX_ORDER][NC];
   logic signed [CW-1:0] req_pt   [NC];
   logic signed [CW-1:0] lane_pts [NC][MAX_ORDER];
   logic signed [CW-1:0] lane_res [NC];

   assign req_pt[0] = req_px;
   assign req_pt[1] = req_py;
   assign req_pt[2] = req_pz;
   assign req_pt[3] = req_pw;

   bct_seq #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .final_point (req_final_point),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .store       (store),
      .npts        (npts),
      .t_out       (t_val),
      .meta        (meta)
   );

   // segment point store; a non-final segment's last point moves to slot 0
   always_ff @(posedge clock) begin
      if (store.wr) begin
         pts_ff[store.slot[SLTW-1:0]] <= req_pt;
      end else if (store.cp) begin
         pts_ff[0] <= pts_ff[store.src[SLTW-1:0]];
      end
   end

   for (genvar c = 0; c < NC; c++) begin : g_lane
      for (genvar k = 0; k < MAX_ORDER; k++) begin : g_col
         assign lane_pts[c][k] = pts_ff[k][c];
      end
      bct_lane #(
         .MAX_ORDER (MAX_ORDER),
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .pts   (lane_pts[c]),
         .npts  (npts),
         .t_in  (t_val),
         .res   (lane_res[c])
      );
   end

   bct_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .lane_res         (lane_res),
      .meta             (meta),
      .rsp_strobe       (rsp_strobe),
      .rsp_cx           (rsp_cx),
      .rsp_cy           (rsp_cy),
      .rsp_cz           (rsp_cz),
      .rsp_cw           (rsp_cw),
      .rsp_sample_index (rsp_sample_index),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

@@ design/bct_lane.sv @@
`timescale 1ns / 1ps

module bct_lane #(
   parameter int MAX_ORDER = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic signed [bct_pkg::COORD_W-1:0]    pts [MAX_ORDER],
   input  logic [bct_pkg::CNT_W-1:0]             npts,
   input  logic [FRAC_BITS:0]                    t_in,
   output logic signed [bct_pkg::COORD_W-1:0]    res
);

   localparam int CW = bct_pkg::COORD_W;
   localparam int TW = FRAC_BITS + 1;
   localparam int NL = MAX_ORDER - 1;

   // a + floor(t * (b - a) / 2^FRAC_BITS)
   function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic [TW-1:0] t);
      logic signed [CW:0]      diff;
      logic signed [CW+TW:0]   prod;
      logic signed [CW+TW:0]   shf;
      diff = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
      prod = diff * $signed({1'b0, t});
      shf  = prod >>> FRAC_BITS;
      return $signed(a + shf[CW-1:0]);
   endfunction

   logic signed [CW-1:0] val_ff  [NL][MAX_ORDER];
   logic [TW-1:0]        t_ff    [NL];
   logic signed [CW-1:0] src_val [NL][MAX_ORDER];
   logic [TW-1:0]        src_t   [NL];

   always_comb begin
      for (int j = 0; j < NL; j++) begin
         if (j == 0) begin
            src_t[j] = t_in;
         end else begin
            src_t[j] = t_ff[j-1];
         end
         for (int k = 0; k < MAX_ORDER; k++) begin
            if (j == 0) begin
               src_val[j][k] = pts[k];
            end else begin
               src_val[j][k] = val_ff[j-1][k];
            end
         end
      end
   end

   // one de casteljau level per stage; levels above the degree pass through
   always_ff @(posedge clock) begin
      for (int j = 0; j < NL; j++) begin
         t_ff[j] <= src_t[j];
         for (int k = 0; k < MAX_ORDER; k++) begin
            if ((k < NL - j) && (int'(npts) > j + 1)) begin
               val_ff[j][k] <= lerp(src_val[j][k],
                                    src_val[j][(k + 1 < MAX_ORDER) ? k + 1 : k],
                                    src_t[j]);
            end else begin
               val_ff[j][k] <= src_val[j][k];
            end
         end
      end
   end

   assign res = val_ff[NL-1][0];

endmodule

@@ design/bct_seq.sv @@
`timescale 1ns / 1ps

module bct_seq #(
   parameter int MAX_ORDER = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          final_point,
   input  logic                          csr_we,
   input  logic [bct_pkg::STEPS_W-1:0]   csr_wdata,
   output bct_pkg::store_ctl_type        store,
   output logic [bct_pkg::CNT_W-1:0]     npts,
   output logic [FRAC_BITS:0]            t_out,
   output bct_pkg::sample_meta_type      meta
);

   localparam int TW  = FRAC_BITS + 1;
   localparam int DCW = $clog2(FRAC_BITS + 1);
   localparam int NL  = MAX_ORDER - 1;
   localparam int SW  = bct_pkg::STEPS_W;
   localparam int CW  = bct_pkg::CNT_W;
   localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

   bct_pkg::seq_state_type state_ff, state_in;

   logic [SW-1:0]  steps_ff, steps_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  npts_ff, npts_in;
   logic           fin_ff, fin_in;
   logic [SW-1:0]  n_ff, n_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [TW-1:0]  quo_ff, quo_in;
   logic [SW-1:0]  idx_ff, idx_in;
   logic [TW-1:0]  t_ff, t_in;
   logic [SW-1:0]  tr_ff, tr_in;

   bct_pkg::sample_meta_type meta_ff [NL];
   bct_pkg::sample_meta_type issue;

   logic          accept;
   logic [CW-1:0] slot;
   logic [CW-1:0] cnt_new;
   logic          eval;
   logic [SW:0]   rem_sh;
   logic          qbit;
   logic [SW:0]   tr_sum;
   logic          last;

   assign busy    = (state_ff != bct_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign slot    = (count_ff >= CW'(MAX_ORDER)) ? CW'(MAX_ORDER - 1) : count_ff;
   assign cnt_new = slot + CW'(1);
   assign eval    = (cnt_new == CW'(MAX_ORDER)) || (final_point && (cnt_new >= CW'(2)));
   assign last    = (state_ff == bct_pkg::ST_EMIT) && (idx_ff == n_ff);

   // restoring divide of 2^FRAC_BITS by steps, one quotient bit a cycle
   assign rem_sh = {rem_ff, (div_cnt_ff == DCW'(FRAC_BITS))};
   assign qbit   = (rem_sh >= {1'b0, n_ff});
   assign tr_sum = {1'b0, tr_ff} + {1'b0, rem_ff};

   always_comb begin
      state_in   = state_ff;
      steps_in   = csr_we ? csr_wdata : steps_ff;
      count_in   = count_ff;
      npts_in    = npts_ff;
      fin_in     = fin_ff;
      n_in       = n_ff;
      div_cnt_in = div_cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      idx_in     = idx_ff;
      t_in       = t_ff;
      tr_in      = tr_ff;
      unique case (state_ff)
         bct_pkg::ST_IDLE: begin
            if (accept) begin
               if (eval) begin
                  state_in   = bct_pkg::ST_DIV;
                  count_in   = cnt_new;
                  fin_in     = final_point;
                  n_in       = (steps_ff == '0) ? SW'(1) : steps_ff;
                  div_cnt_in = DCW'(FRAC_BITS);
                  rem_in     = '0;
                  quo_in     = '0;
               end else begin
                  count_in = final_point ? '0 : cnt_new;
               end
            end
         end
         bct_pkg::ST_DIV: begin
            rem_in     = qbit ? SW'(rem_sh - {1'b0, n_ff}) : SW'(rem_sh);
            quo_in     = {quo_ff[TW-2:0], qbit};
            div_cnt_in = div_cnt_ff - DCW'(1);
            if (div_cnt_ff == '0) begin
               // degree changes only once the previous run has left the lanes
               state_in = bct_pkg::ST_EMIT;
               npts_in  = count_ff;
               idx_in   = '0;
               t_in     = '0;
               tr_in    = '0;
            end
         end
         bct_pkg::ST_EMIT: begin
            // quo_ff holds the t step, rem_ff its remainder
            idx_in = idx_ff + SW'(1);
            if (tr_sum >= {1'b0, n_ff}) begin
               t_in  = t_ff + quo_ff + TW'(1);
               tr_in = SW'(tr_sum - {1'b0, n_ff});
            end else begin
               t_in  = t_ff + quo_ff;
               tr_in = SW'(tr_sum);
            end
            if (last) begin
               state_in = bct_pkg::ST_IDLE;
               count_in = fin_ff ? '0 : CW'(1);
            end
         end
         default: begin
            state_in = bct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bct_pkg::ST_IDLE;
         steps_ff <= bct_pkg::STEPS_RESET;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
         count_ff <= count_in;
      end
      npts_ff    <= npts_in;
      fin_ff     <= fin_in;
      n_ff       <= n_in;
      div_cnt_ff <= div_cnt_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      idx_ff     <= idx_in;
      t_ff       <= t_in;
      tr_ff      <= tr_in;
   end

   assign issue.valid   = (state_ff == bct_pkg::ST_EMIT);
   assign issue.idx     = idx_ff;
   assign issue.run_end = (idx_ff == n_ff);

   // tag delay matches the lane depth
   always_ff @(posedge clock) begin
      for (int j = 0; j < NL; j++) begin
         if (reset) begin
            meta_ff[j] <= '0;
         end else if (j == 0) begin
            meta_ff[j] <= issue;
         end else begin
            meta_ff[j] <= meta_ff[j-1];
         end
      end
   end

   assign meta        = meta_ff[NL-1];
   assign t_out       = t_ff;
   assign npts        = npts_ff;
   assign store.wr    = accept;
   assign store.slot  = slot;
   assign store.cp    = last && !fin_ff;
   assign store.src   = npts_ff - CW'(1);

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bct_pkg::ST_IDLE) |-> (count_ff < CW'(MAX_ORDER)))
      else $error("point count out of range while idle");

   a_no_eval_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !eval) |=> (state_ff == bct_pkg::ST_IDLE))
      else $error("item without a segment started an evaluation");

   a_t_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bct_pkg::ST_EMIT) |-> (t_ff <= T_ONE))
      else $error("t above one");

   a_last_t_one: assert property (@(posedge clock) disable iff (reset)
      last |-> (t_ff == T_ONE))
      else $error("last sample of a run is not at t of one");

   a_first_t_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bct_pkg::ST_EMIT && idx_ff == '0) |-> (t_ff == '0))
      else $error("first sample of a run is not at t of zero");

endmodule

@@ design/bct_merge.sv @@
`timescale 1ns / 1ps

module bct_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [bct_pkg::COORD_W-1:0]  lane_res [bct_pkg::NUM_COORDS],
   input  bct_pkg::sample_meta_type            meta,
   output logic                                rsp_strobe,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cx,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cy,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cz,
   output logic signed [bct_pkg::COORD_W-1:0]  rsp_cw,
   output logic [bct_pkg::IDX_W-1:0]           rsp_sample_index,
   output logic                                rsp_run_end
);

   logic                               strobe_ff;
   logic signed [bct_pkg::COORD_W-1:0] cx_ff, cy_ff, cz_ff, cw_ff;
   logic [bct_pkg::IDX_W-1:0]          idx_ff;
   logic                               end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= meta.valid;
      end
      cx_ff  <= lane_res[0];
      cy_ff  <= lane_res[1];
      cz_ff  <= lane_res[2];
      cw_ff  <= lane_res[3];
      idx_ff <= meta.idx;
      end_ff <= meta.run_end;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_cx           = cx_ff;
   assign rsp_cy           = cy_ff;
   assign rsp_cz           = cz_ff;
   assign rsp_cw           = cw_ff;
   assign rsp_sample_index = idx_ff;
   assign rsp_run_end      = strobe_ff && end_ff;

endmodule

@@ dv/bezier_chain_tessellator_top_test.sv @@
`timescale 1ns / 1ps

module bezier_chain_tessellator_top_test;

   localparam int MAX_ORDER   = 4;
   localparam int FRAC_BITS   = 16;
   localparam int SETTLE      = 2 * MAX_ORDER + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_DIR     = 26;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_WORDS = 56;

   typedef logic [0:bct_pkg::NUM_COORDS-1][bct_pkg::COORD_W-1:0] coord_vec_type;

   typedef struct packed {
      coord_vec_type             pt;
      logic [bct_pkg::IDX_W-1:0] idx;
      logic                      run_end;
   } curve_sample_type;

   typedef enum logic {
      ROW_POINT,
      ROW_STEPS
   } row_kind_type;

   // pinned rows run at one step, so both samples are the segment end points
   typedef struct packed {
      row_kind_type                kind;
      logic [bct_pkg::STEPS_W-1:0] steps;
      coord_vec_type               pt;
      logic                        fin;
      logic                        pinned;
      coord_vec_type               first_pt;
   } stim_row_type;

   localparam logic [bct_pkg::COORD_W-1:0] MIN_C = 32'h8000_0000;
   localparam logic [bct_pkg::COORD_W-1:0] MAX_C = 32'h7fff_ffff;
   localparam logic [bct_pkg::COORD_W-1:0] NEG1  = 32'hffff_ffff;
   localparam coord_vec_type               NO_PT = '0;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic signed [bct_pkg::COORD_W-1:0] req_px = '0;
   logic signed [bct_pkg::COORD_W-1:0] req_py = '0;
   logic signed [bct_pkg::COORD_W-1:0] req_pz = '0;
   logic signed [bct_pkg::COORD_W-1:0] req_pw = '0;
   logic                               req_final_point = 1'b0;
   logic                               csr_we = 1'b0;
   logic [bct_pkg::STEPS_W-1:0]        csr_wdata = '0;
   logic                               rsp_strobe;
   logic signed [bct_pkg::COORD_W-1:0] rsp_cx;
   logic signed [bct_pkg::COORD_W-1:0] rsp_cy;
   logic signed [bct_pkg::COORD_W-1:0] rsp_cz;
   logic signed [bct_pkg::COORD_W-1:0] rsp_cw;
   logic [bct_pkg::IDX_W-1:0]          rsp_sample_index;
   logic                               rsp_run_end;

   logic                               busy_seen = 1'b0;

   // curve model state
   coord_vec_type                      held_pts [MAX_ORDER];
   int unsigned                        held_count = 0;
   logic [bct_pkg::STEPS_W-1:0]        steps_cfg = bct_pkg::STEPS_RESET;

   curve_sample_type                   seg_samples[$];
   curve_sample_type                   pending_samples[$];
   int                                 mismatch_count = 0;

   stim_row_type dir_rows [NUM_DIR] = '{
      // lone point chain, nothing comes out
      '{ROW_POINT, 6'd0, '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000},
        1'b1, 1'b0, NO_PT},
      // full cubic at the reset step count, then a quadratic tail
      '{ROW_POINT, 6'd0, '{32'h0000_0000, 32'h0001_0000, 32'hffff_0000, 32'h0010_8000},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h0004_0000, 32'hfffc_0000, 32'h0000_8000, 32'h0001_0000},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h0008_4000, 32'h0002_0000, 32'hfff0_0001, 32'h0000_0001},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h000c_0000, 32'h0000_0003, 32'h0001_0000, 32'hffff_ffff},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h0010_0000, 32'h1234_5678, 32'hedcb_a987, 32'h0000_0000},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'hfff0_0000, 32'h0000_ffff, 32'h0100_0000, 32'h8000_0001},
        1'b1, 1'b0, NO_PT},
      '{ROW_STEPS, 6'd1, NO_PT, 1'b0, 1'b0, NO_PT},
      // line between extremes
      '{ROW_POINT, 6'd0, '{MIN_C, MAX_C, 32'h0, NEG1}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MAX_C, MIN_C, NEG1, 32'h0}, 1'b1, 1'b1,
        '{MIN_C, MAX_C, 32'h0, NEG1}},
      '{ROW_POINT, 6'd0, '{32'h0001_0000, MIN_C, MAX_C, 32'h0000_0100}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MAX_C, MAX_C, MIN_C, MIN_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MIN_C, MIN_C, MAX_C, MAX_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h0002_0000, 32'hfffe_0000, 32'h5555_5555, 32'haaaa_aaaa},
        1'b0, 1'b1, '{32'h0001_0000, MIN_C, MAX_C, 32'h0000_0100}},
      // chain continues from the kept point, then ends on a line
      '{ROW_POINT, 6'd0, '{NEG1, 32'h0, MIN_C, MAX_C}, 1'b1, 1'b1,
        '{32'h0002_0000, 32'hfffe_0000, 32'h5555_5555, 32'haaaa_aaaa}},
      '{ROW_STEPS, 6'd0, NO_PT, 1'b0, 1'b0, NO_PT},
      // zero steps acts as one
      '{ROW_POINT, 6'd0, '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004},
        1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'hffff_fff0, MAX_C, MIN_C, 32'h0000_0040}, 1'b1, 1'b1,
        '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004}},
      '{ROW_STEPS, 6'd63, NO_PT, 1'b0, 1'b0, NO_PT},
      // extreme cubic, then an extreme quadratic, at the largest step count
      '{ROW_POINT, 6'd0, '{MAX_C, MIN_C, MAX_C, MIN_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MIN_C, MAX_C, MIN_C, MAX_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MAX_C, MAX_C, MIN_C, MIN_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MIN_C, MIN_C, MAX_C, MAX_C}, 1'b1, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{32'h0, MAX_C, NEG1, MIN_C}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MIN_C, 32'h0, MAX_C, NEG1}, 1'b0, 1'b0, NO_PT},
      '{ROW_POINT, 6'd0, '{MAX_C, NEG1, 32'h0, MAX_C}, 1'b1, 1'b0, NO_PT}
   };

   bezier_chain_tessellator_top #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_px           (req_px),
      .req_py           (req_py),
      .req_pz           (req_pz),
      .req_pw           (req_pw),
      .req_final_point  (req_final_point),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_cx           (rsp_cx),
      .rsp_cy           (rsp_cy),
      .rsp_cz           (rsp_cz),
      .rsp_cw           (rsp_cw),
      .rsp_sample_index (rsp_sample_index),
      .rsp_run_end      (rsp_run_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // outputs only move on the rising edge, so mid-cycle samples are stable
   always @(negedge clock) begin
      busy_seen <= busy;
   end

   // one de casteljau coordinate, products floored by the arithmetic shift
   function automatic logic [bct_pkg::COORD_W-1:0] blend_coord(int unsigned npts, int c,
                                                               longint t);
      longint v [MAX_ORDER];
      longint r;
      for (int k = 0; k < npts; k++) v[k] = longint'($signed(held_pts[k][c]));
      for (int deg = npts - 1; deg > 0; deg--)
         for (int k = 0; k < deg; k++)
            v[k] = v[k] + ((t * (v[k + 1] - v[k])) >>> FRAC_BITS);
      r = v[0];
      return r[bct_pkg::COORD_W-1:0];
   endfunction

   task automatic tessellate_word(input coord_vec_type pt, input logic fin);
      int unsigned      slot;
      int unsigned      n;
      bit               evaluated;
      longint           t;
      curve_sample_type s;
      seg_samples.delete();
      evaluated = 1'b0;
      slot = (held_count >= MAX_ORDER) ? MAX_ORDER - 1 : held_count;
      held_pts[slot] = pt;
      held_count = slot + 1;
      if (held_count == MAX_ORDER || (fin && held_count >= 2)) begin
         n = (steps_cfg == 0) ? 1 : steps_cfg;
         for (int i = 0; i <= n; i++) begin
            t = (longint'(i) << FRAC_BITS) / longint'(n);
            for (int c = 0; c < bct_pkg::NUM_COORDS; c++)
               s.pt[c] = blend_coord(held_count, c, t);
            s.idx = i[bct_pkg::IDX_W-1:0];
            s.run_end = (i == n);
            seg_samples.push_back(s);
         end
         evaluated = 1'b1;
      end
      if (fin) begin
         held_count = 0;
      end else if (evaluated) begin
         held_pts[0] = held_pts[held_count - 1];
         held_count = 1;
      end
   endtask

   task automatic report_mismatch(input string what, input curve_sample_type want,
                                  input curve_sample_type got);
      if (mismatch_count < 10) begin
         $display("%0t %s: expected %h %h %h %h idx %0d end %0d, got %h %h %h %h idx %0d end %0d",
                  $realtime, what, want.pt[0], want.pt[1], want.pt[2], want.pt[3], want.idx,
                  want.run_end, got.pt[0], got.pt[1], got.pt[2], got.pt[3], got.idx,
                  got.run_end);
      end
      mismatch_count++;
   endtask

   always @(negedge clock) begin : rsp_check
      curve_sample_type got;
      curve_sample_type want;
      if (!reset && rsp_strobe) begin
         got.pt = '{rsp_cx, rsp_cy, rsp_cz, rsp_cw};
         got.idx = rsp_sample_index;
         got.run_end = rsp_run_end;
         if (pending_samples.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
         end else begin
            want = pending_samples.pop_front();
            if (want.pt[0] != got.pt[0] || want.pt[1] != got.pt[1] ||
                want.pt[2] != got.pt[2] || want.pt[3] != got.pt[3] ||
                want.idx != got.idx || want.run_end != got.run_end) begin
               report_mismatch("mismatch", want, got);
            end
         end
      end
   end

   task automatic idle_burst(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_steps(input logic [bct_pkg::STEPS_W-1:0] value);
      drain_results();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      steps_cfg = value;
      csr_we <= 1'b0;
   endtask

   task automatic send_word(input coord_vec_type pt, input logic fin, input logic pinned,
                            input coord_vec_type first_pt);
      curve_sample_type s;
      req_px <= pt[0];
      req_py <= pt[1];
      req_pz <= pt[2];
      req_pw <= pt[3];
      req_final_point <= fin;
      start <= 1'b1;
      do @(posedge clock); while (busy_seen);
      tessellate_word(pt, fin);
      if (pinned) begin
         s.pt = first_pt;
         s.idx = '0;
         s.run_end = 1'b0;
         pending_samples.push_back(s);
         s.pt = pt;
         s.idx = bct_pkg::IDX_W'(1);
         s.run_end = 1'b1;
         pending_samples.push_back(s);
      end else begin
         foreach (seg_samples[k]) pending_samples.push_back(seg_samples[k]);
      end
   endtask

   function automatic logic [bct_pkg::COORD_W-1:0] rand_coord();
      unique case ($urandom_range(0, 9))
         0: return MIN_C;
         1: return MAX_C;
         2, 3, 4: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic coord_vec_type rand_point();
      coord_vec_type p;
      for (int c = 0; c < bct_pkg::NUM_COORDS; c++) p[c] = rand_coord();
      return p;
   endfunction

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int  sent;
      int  chain_len;
      bit  idle_on;
      bit  gappy;
      bit  noisy;
      bit  paused;
      bit  fin;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < NUM_DIR; r++) begin
         if (dir_rows[r].kind == ROW_STEPS)
            write_steps(dir_rows[r].steps);
         else
            send_word(dir_rows[r].pt, dir_rows[r].fin, dir_rows[r].pinned,
                      dir_rows[r].first_pt);
      end

      paused = 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         unique case (ph)
            0: write_steps(6'd63);
            1: write_steps(6'd1);
            2: write_steps(6'($urandom_range(2, 12)));
            3: write_steps(6'd0);
            4: write_steps(6'($urandom_range(1, 63)));
            default: write_steps(6'($urandom_range(3, 9)));
         endcase
         idle_on = (ph != NUM_PHASES - 1);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            gappy = idle_on && ($urandom_range(0, 1) == 1);
            // mostly proper chains, some with stray ends and lone points
            noisy = ($urandom_range(0, 7) == 0);
            chain_len = noisy ? $urandom_range(1, 6) : $urandom_range(2, 9);
            for (int k = 0; k < chain_len; k++) begin
               if (gappy && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 17));
               fin = noisy ? ($urandom_range(0, 2) == 0) : (k == chain_len - 1);
               send_word(rand_point(), fin, 1'b0, NO_PT);
               sent++;
            end
            // hold off once until the block has emptied
            if (ph == 2 && !paused && sent >= PHASE_WORDS / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
      end

      start <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/bct_pkg.sv
design/bct_lane.sv
design/bct_seq.sv
design/bct_merge.sv
design/bezier_chain_tessellator_top.sv
dv/bezier_chain_tessellator_top_test.sv
